[design/nfarm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfarm_pkg
// Shared types, codes and command/status structs of the NFA regex matcher.
// ----------------------------------------------------------------------------
package nfarm_pkg;

  localparam int NumStatesDefault = 64;
  localparam int KindW  = 2;
  localparam int IndexW = 6;
  localparam int TypeW  = 2;
  localparam int SuccW  = 7;
  localparam int CharW  = 8;
  localparam int ClassW = 1 << CharW;

  typedef enum logic [KindW-1:0] {
    KIND_DEFINE = 2'd0,
    KIND_CLASS  = 2'd1,
    KIND_TEXT   = 2'd2,
    KIND_BEGIN  = 2'd3
  } kind_t;

  typedef enum logic [TypeW-1:0] {
    TYPE_CLASS = 2'd0,
    TYPE_ANY   = 2'd1,
    TYPE_MATCH = 2'd2,
    TYPE_SPLIT = 2'd3
  } stype_t;

  typedef enum logic [1:0] {
    PUSH_NONE   = 2'd0,
    PUSH_START  = 2'd1,
    PUSH_FIRST  = 2'd2,
    PUSH_SECOND = 2'd3
  } push_sel_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IndexW-1:0] state_index;
    logic [TypeW-1:0]  state_type;
    logic [SuccW-1:0]  next_first;
    logic [SuccW-1:0]  next_second;
    logic              negate;
    logic [CharW-1:0]  char_value;
  } item_t;

  typedef struct packed {
    logic [TypeW-1:0] state_type;
    logic [SuccW-1:0] next_first;
    logic [SuccW-1:0] next_second;
    logic             negate;
  } entry_t;

  typedef struct packed {
    logic      load_item;
    logic      clear_step;
    logic      wr_define;
    logic      rd_class;
    logic      wr_class;
    logic      scan_rd;
    logic      scan_inc;
    push_sel_t push_sel;
    logic      pop_rd;
    logic      fetch;
    logic      add_next;
    logic      commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             stack_empty;
    logic             scan_done;
    logic             scan_active;
    logic             is_split;
    logic             moves;
    logic             out_busy;
  } dp_status_t;

endpackage

[design/nfarm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfarm_if
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface nfarm_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [nfarm_pkg::KindW-1:0]              kind;
  logic [nfarm_pkg::IndexW-1:0]             state_index;
  logic [nfarm_pkg::TypeW-1:0]              state_type;
  logic [nfarm_pkg::SuccW-1:0]              next_first;
  logic [nfarm_pkg::SuccW-1:0]              next_second;
  logic                                     negate;
  logic [nfarm_pkg::CharW-1:0]              char_value;

  modport source (
    output valid, kind, state_index, state_type, next_first, next_second, negate,
           char_value,
    input  ready
  );
  modport sink (
    input  valid, kind, state_index, state_type, next_first, next_second, negate,
           char_value,
    output ready
  );
endinterface

interface nfarm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic dead;

  modport source (output valid, matched, dead, input ready);
  modport sink (input valid, matched, dead, output ready);
endinterface

[design/nfa_regex_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_regex_matcher
// Thompson NFA simulation over a byte stream with a loadable state table.
// ----------------------------------------------------------------------------
// usage
// - in_ch carries define, class, begin and text transactions; out_ch carries
//   one result (matched, dead) per begin or text transaction
// - cfg_wr_en/cfg_wr_data write start_state at any clock edge while idle
// - define writes the entry, class add reads then writes the row; neither gives a result
// - begin: pushes start_state, then pops, fetches and examines each state
//   reached through the closure, with a second push step per split state
// - text: scans every state index, reads each active state and runs the
//   closure from the first successor of each active state that moves, with a
//   second push step per split; scan and closure share the single-port state table
// - one item is in work at a time; in_ch.ready is high only when idle
// - the result sits in an output register; a new item is taken while it
//   waits, and the next result holds in the report step until out_ch frees
// - reset empties the active set, zeroes start_state and marks all class
//   rows empty through per-row valid bits, so no clearing pass is needed
// - table entries read before being defined give undefined results
// ----------------------------------------------------------------------------
module nfa_regex_matcher #(
  parameter int NUM_STATES = nfarm_pkg::NumStatesDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  nfarm_in_if.sink                     in_ch,
  nfarm_out_if.source                  out_ch,
  input  logic                         cfg_wr_en,
  input  logic [nfarm_pkg::IndexW-1:0] cfg_wr_data
);
  import nfarm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  item_t      in_item;
  logic       in_acc;

  // pack the input transaction for the datapath
  assign in_item = '{kind: in_ch.kind, state_index: in_ch.state_index,
                     state_type: in_ch.state_type, next_first: in_ch.next_first,
                     next_second: in_ch.next_second, negate: in_ch.negate,
                     char_value: in_ch.char_value};

  assign in_acc = in_ch.valid && in_ch.ready;

  // sequencer
  nfarm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // table, sets, closure stack and result register
  nfarm_dp #(
    .NUM_STATES (NUM_STATES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_matched (out_ch.matched),
    .out_dead    (out_ch.dead)
  );

  // a reported match implies a non-empty set
  a_match_not_dead: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.matched && out_ch.dead))
    else $error("matched and dead both set");

  // a begin or text transaction keeps the block busy the next cycle
  a_busy_after_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_ch.kind == KIND_TEXT || in_ch.kind == KIND_BEGIN) |=> !in_ch.ready)
    else $error("ready during step");

  // table loads never produce a result
  a_no_result_on_load: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_ch.kind == KIND_DEFINE || in_ch.kind == KIND_CLASS)
    |=> ##1 !$rose(out_ch.valid))
    else $error("result after table load");

  // the closure never starts without a cleared stack from the accept
  a_stack_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |=> status.stack_empty)
    else $error("stack not empty at step start");

endmodule

[design/nfarm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfarm_ctrl
// Sequencer: table loads, active-set scan, split closure and result hand-off.
// ----------------------------------------------------------------------------
module nfarm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [nfarm_pkg::KindW-1:0] in_kind,
  output logic                   in_ready,
  input  nfarm_pkg::dp_status_t  status,
  output nfarm_pkg::ctrl_cmd_t   cmd
);
  import nfarm_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_DEF     = 12'b000000000010,
    ST_CLS_RD  = 12'b000000000100,
    ST_CLS_WR  = 12'b000000001000,
    ST_SEED    = 12'b000000010000,
    ST_SCAN    = 12'b000000100000,
    ST_S_EXAM  = 12'b000001000000,
    ST_C_POP   = 12'b000010000000,
    ST_C_FETCH = 12'b000100000000,
    ST_C_EXAM  = 12'b001000000000,
    ST_C_PUSH2 = 12'b010000000000,
    ST_REPORT  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.push_sel = PUSH_NONE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          unique case (kind_t'(in_kind))
            KIND_DEFINE: state_next = ST_DEF;
            KIND_CLASS:  state_next = ST_CLS_RD;
            KIND_TEXT: begin
              cmd.clear_step = 1'b1;
              state_next     = ST_SCAN;
            end
            KIND_BEGIN: begin
              cmd.clear_step = 1'b1;
              state_next     = ST_SEED;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DEF: begin
        cmd.wr_define = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_CLS_RD: begin
        cmd.rd_class = 1'b1;
        state_next   = ST_CLS_WR;
      end
      ST_CLS_WR: begin
        cmd.wr_class = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_SEED: begin
        cmd.push_sel = PUSH_START;
        state_next   = ST_C_POP;
      end
      ST_SCAN: begin
        priority if (status.scan_done) begin
          state_next = ST_REPORT;
        end else if (status.scan_active) begin
          cmd.scan_rd  = 1'b1;
          cmd.scan_inc = 1'b1;
          state_next   = ST_S_EXAM;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_S_EXAM: begin
        if (status.moves) begin
          cmd.push_sel = PUSH_FIRST;
          state_next   = ST_C_POP;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_C_POP: begin
        if (status.stack_empty) begin
          state_next = (status.kind == KIND_BEGIN) ? ST_REPORT : ST_SCAN;
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = ST_C_FETCH;
        end
      end
      ST_C_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_C_EXAM;
      end
      ST_C_EXAM: begin
        if (status.is_split) begin
          cmd.push_sel = PUSH_FIRST;
          state_next   = ST_C_PUSH2;
        end else begin
          cmd.add_next = 1'b1;
          state_next   = ST_C_POP;
        end
      end
      ST_C_PUSH2: begin
        cmd.push_sel = PUSH_SECOND;
        state_next   = ST_C_POP;
      end
      ST_REPORT: begin
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[design/nfarm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfarm_dp
// Datapath: state table, class rows, active/next sets, closure stack, result.
// ----------------------------------------------------------------------------
module nfarm_dp #(
  parameter int NUM_STATES = nfarm_pkg::NumStatesDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nfarm_pkg::item_t              in_item,
  input  logic                          cfg_wr_en,
  input  logic [nfarm_pkg::IndexW-1:0]  cfg_wr_data,
  input  nfarm_pkg::ctrl_cmd_t          cmd,
  output nfarm_pkg::dp_status_t         status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_matched,
  output logic                          out_dead
);
  import nfarm_pkg::*;

  localparam int SW = $clog2(NUM_STATES);

  item_t                 item;
  logic [IndexW-1:0]     start_state;

  entry_t                tbl [NUM_STATES];
  entry_t                tbl_rd;
  logic [ClassW-1:0]     bm [NUM_STATES];
  logic [ClassW-1:0]     bm_rd;
  logic [NUM_STATES-1:0] row_valid;
  logic                  rv_rd;

  logic [SW-1:0]         stk [NUM_STATES];
  logic [SW-1:0]         stk_rd;
  logic [SW:0]           top;
  logic [SW:0]           top_m1;

  logic [NUM_STATES-1:0] active;
  logic [NUM_STATES-1:0] next_set;
  logic [NUM_STATES-1:0] visited;
  logic [SW:0]           scan_i;
  logic [SW-1:0]         cur;
  logic                  hit;
  logic                  any;

  logic                  idx_ok;
  logic [SW-1:0]         widx;
  logic [SW-1:0]         scan_idx;
  logic [SuccW-1:0]      cand;
  logic                  cand_in;
  logic [SW-1:0]         cand_idx;
  logic                  push_do;
  logic [ClassW-1:0]     cls_row;
  logic                  in_class;

  assign idx_ok   = 32'(item.state_index) < NUM_STATES;
  assign widx     = SW'(item.state_index);
  assign scan_idx = scan_i[SW-1:0];
  assign top_m1   = top - (SW+1)'(1);

  always_comb begin
    unique case (cmd.push_sel)
      PUSH_START:  cand = SuccW'(start_state);
      PUSH_FIRST:  cand = tbl_rd.next_first;
      PUSH_SECOND: cand = tbl_rd.next_second;
      default:     cand = '0;
    endcase
  end

  assign cand_in  = 32'(cand) < NUM_STATES;
  assign cand_idx = SW'(cand);
  assign push_do  = (cmd.push_sel != PUSH_NONE) && cand_in && !visited[cand_idx];

  // class row after adding the item's character; an unloaded row counts as empty
  assign cls_row  = (rv_rd ? bm_rd : '0) | (ClassW'(1) << item.char_value);
  assign in_class = rv_rd && bm_rd[item.char_value];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= '0;
    end else if (cfg_wr_en) begin
      start_state <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_item;
    end
  end

  // state table memory
  always_ff @(posedge clk) begin
    if (cmd.wr_define && idx_ok) begin
      tbl[widx] <= '{state_type: item.state_type, next_first: item.next_first,
                     next_second: item.next_second, negate: item.negate};
    end
    if (cmd.scan_rd) begin
      tbl_rd <= tbl[scan_idx];
    end else if (cmd.fetch) begin
      tbl_rd <= tbl[stk_rd];
    end
  end

  // class rows, one 256-bit word per state
  always_ff @(posedge clk) begin
    if (cmd.wr_define && idx_ok) begin
      bm[widx] <= '0;
    end else if (cmd.wr_class && idx_ok) begin
      bm[widx] <= cls_row;
    end
    if (cmd.scan_rd) begin
      bm_rd <= bm[scan_idx];
      rv_rd <= row_valid[scan_idx];
    end else if (cmd.rd_class) begin
      bm_rd <= bm[widx];
      rv_rd <= row_valid[widx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.wr_define && idx_ok) begin
      row_valid[widx] <= 1'b1;
    end
  end

  // closure work stack
  always_ff @(posedge clk) begin
    if (push_do) begin
      stk[top[SW-1:0]] <= cand_idx;
    end
    if (cmd.pop_rd) begin
      stk_rd <= stk[top_m1[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top      <= '0;
      scan_i   <= '0;
      active   <= '0;
      next_set <= '0;
      visited  <= '0;
      hit      <= 1'b0;
      any      <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        top      <= '0;
        scan_i   <= '0;
        next_set <= '0;
        visited  <= '0;
        hit      <= 1'b0;
        any      <= 1'b0;
      end else begin
        if (push_do) begin
          top               <= top + (SW+1)'(1);
          visited[cand_idx] <= 1'b1;
        end else if (cmd.pop_rd) begin
          top <= top_m1;
        end
        if (cmd.scan_inc) begin
          scan_i <= scan_i + (SW+1)'(1);
        end
        if (cmd.add_next) begin
          next_set[cur] <= 1'b1;
          any           <= 1'b1;
          if (tbl_rd.state_type == TYPE_MATCH) begin
            hit <= 1'b1;
          end
        end
      end
      if (cmd.commit) begin
        active <= next_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      cur <= stk_rd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_matched <= hit;
      out_dead    <= !any;
    end
  end

  always_comb begin
    status.kind        = item.kind;
    status.stack_empty = (top == '0);
    status.scan_done   = (scan_i == (SW+1)'(NUM_STATES));
    status.scan_active = active[scan_idx];
    status.is_split    = (tbl_rd.state_type == TYPE_SPLIT);
    unique case (stype_t'(tbl_rd.state_type))
      TYPE_ANY:   status.moves = 1'b1;
      TYPE_CLASS: status.moves = in_class ^ tbl_rd.negate;
      default:    status.moves = 1'b0;
    endcase
    status.out_busy    = out_valid && !out_ready;
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the NFA regex matcher. A queue of pending
// transactions feeds a clocked driver. A clocked monitor compares each result
// with the expected results. These come from a behavioral copy of the NFA
// table, the class bitmaps and the active set, which is updated at every
// accepted transaction. Both channels stall at random but in the calm phase.
// start_state is rewritten between phases only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import nfarm_pkg::*;

  localparam int NS = NumStatesDefault;

  typedef struct packed {
    logic matched;
    logic dead;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [IndexW-1:0] cfg_wr_data = '0;

  nfarm_in_if  in_ch ();
  nfarm_out_if out_ch ();

  nfa_regex_matcher #(.NUM_STATES(NS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // ---------------- shadow copy of the matcher ----------------
  stype_t           tbl_type [NS];
  logic [SuccW-1:0] tbl_succ1 [NS];
  logic [SuccW-1:0] tbl_succ2 [NS];
  logic             tbl_neg [NS];
  bit               char_class [NS][256];
  bit               active [NS];
  bit               next_active [NS];
  bit               seen [NS];
  logic [IndexW-1:0] entry_state = '0;

  item_t    pending [$];
  verdict_t expected_verdicts [$];
  int       errors = 0;
  int       n_results = 0;
  int       n_matches = 0;
  bit       calm = 1'b0;

  // split closure of one state into next_active, shared visit marks
  function automatic void close_into(int idx);
    int stack [$];
    int s;
    int a;
    int b;
    if (idx >= NS || seen[idx]) return;
    seen[idx] = 1'b1;
    stack.push_back(idx);
    while (stack.size() > 0) begin
      s = stack.pop_back();
      if (tbl_type[s] == TYPE_SPLIT) begin
        a = int'(tbl_succ1[s]);
        b = int'(tbl_succ2[s]);
        if (a < NS && !seen[a]) begin
          seen[a] = 1'b1;
          stack.push_back(a);
        end
        if (b < NS && !seen[b]) begin
          seen[b] = 1'b1;
          stack.push_back(b);
        end
      end else begin
        next_active[s] = 1'b1;
      end
    end
  endfunction

  // apply one accepted transaction, queue the result it causes
  function automatic void apply_item(item_t it);
    bit       hit;
    bit       in_cls;
    verdict_t v;
    case (kind_t'(it.kind))
      KIND_DEFINE: begin
        tbl_type[it.state_index]  = stype_t'(it.state_type);
        tbl_succ1[it.state_index] = it.next_first;
        tbl_succ2[it.state_index] = it.next_second;
        tbl_neg[it.state_index]   = it.negate;
        for (int c = 0; c < 256; c++) char_class[it.state_index][c] = 1'b0;
      end
      KIND_CLASS: char_class[it.state_index][it.char_value] = 1'b1;
      default: begin
        for (int i = 0; i < NS; i++) begin
          next_active[i] = 1'b0;
          seen[i] = 1'b0;
        end
        if (kind_t'(it.kind) == KIND_BEGIN) begin
          close_into(int'(entry_state));
        end else begin
          for (int i = 0; i < NS; i++) begin
            if (active[i]) begin
              in_cls = char_class[i][it.char_value];
              if (tbl_type[i] == TYPE_ANY ||
                  (tbl_type[i] == TYPE_CLASS && (in_cls ^ tbl_neg[i])))
                close_into(int'(tbl_succ1[i]));
            end
          end
        end
        hit = 1'b0;
        v.dead = 1'b1;
        for (int i = 0; i < NS; i++) begin
          active[i] = next_active[i];
          if (active[i]) begin
            v.dead = 1'b0;
            if (tbl_type[i] == TYPE_MATCH) hit = 1'b1;
          end
        end
        v.matched = hit;
        expected_verdicts.push_back(v);
      end
    endcase
  endfunction

  // ---------------- stimulus builders ----------------
  function automatic item_t define_item(int idx, stype_t t, int s1, int s2, bit ng);
    item_t it;
    it = '0;
    it.kind = KIND_DEFINE;
    it.state_index = IndexW'(idx);
    it.state_type = t;
    it.next_first = SuccW'(s1);
    it.next_second = SuccW'(s2);
    it.negate = ng;
    it.char_value = CharW'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic item_t byte_item(kind_t k, int idx, int ch);
    item_t it;
    it = '0;
    it.kind = k;
    it.state_index = IndexW'(idx);
    it.char_value = CharW'(ch);
    // unused fields toggle too
    it.state_type = TypeW'($urandom_range(0, 3));
    it.next_first = SuccW'($urandom_range(0, 127));
    it.next_second = SuccW'($urandom_range(0, 127));
    it.negate = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // mostly a small alphabet so classes and text meet often
  function automatic int pick_char();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(97, 102);
  endfunction

  // successor: mostly a real state, sometimes "none" in any encoding
  function automatic int pick_succ();
    if ($urandom_range(0, 11) == 0) return $urandom_range(64, 127);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 7);
    return $urandom_range(0, 63);
  endfunction

  function automatic item_t rand_define(int idx);
    int     r;
    stype_t t;
    r = $urandom_range(0, 99);
    t = (r < 40) ? TYPE_CLASS : (r < 55) ? TYPE_ANY : (r < 70) ? TYPE_MATCH : TYPE_SPLIT;
    return define_item(idx, t, pick_succ(), pick_succ(), 1'($urandom_range(0, 1)));
  endfunction

  function automatic item_t rand_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return rand_define($urandom_range(0, 63));
    if (r < 22) return byte_item(KIND_CLASS, $urandom_range(0, 63), pick_char());
    if (r < 32) return byte_item(KIND_BEGIN, $urandom_range(0, 63), pick_char());
    return byte_item(KIND_TEXT, $urandom_range(0, 63), pick_char());
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid && in_ch.ready) begin
        apply_item(pending.pop_front());
      end
      if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= pending[0].kind;
        in_ch.state_index <= pending[0].state_index;
        in_ch.state_type  <= pending[0].state_type;
        in_ch.next_first  <= pending[0].next_first;
        in_ch.next_second <= pending[0].next_second;
        in_ch.negate      <= pending[0].negate;
        in_ch.char_value  <= pending[0].char_value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.state_index = '0;
    in_ch.state_type = '0;
    in_ch.next_first = '0;
    in_ch.next_second = '0;
    in_ch.negate = 1'b0;
    in_ch.char_value = '0;
    out_ch.ready = 1'b0;
  end

  // ---------------- monitor ----------------
  task automatic report_mismatch(string what, verdict_t got, verdict_t want);
    $display("[%0t] mismatch on %s: matched %0b dead %0b, expected matched %0b dead %0b",
             $realtime, what, got.matched, got.dead, want.matched, want.dead);
    errors++;
  endtask

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.matched = out_ch.matched;
        got.dead = out_ch.dead;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result", got, '0);
        end else begin
          want = expected_verdicts.pop_front();
          n_results++;
          if (want.matched) n_matches++;
          if (got !== want) report_mismatch("result", got, want);
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  // ---------------- sequencing ----------------
  // wait until every transaction is through, then let the block settle
  task automatic wait_idle();
    while (pending.size() > 0 || expected_verdicts.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_start(int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= IndexW'(val);
    entry_state = IndexW'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int val;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // text before any begin: empty set stays empty
    pending.push_back(byte_item(KIND_TEXT, 0, 8'h00));
    // small hand-built pattern: split into class path and a self-looping split
    pending.push_back(define_item(0, TYPE_SPLIT, 1, 4, 1'b0));
    pending.push_back(define_item(1, TYPE_CLASS, 2, 64, 1'b0));
    pending.push_back(byte_item(KIND_CLASS, 1, 97));
    pending.push_back(define_item(2, TYPE_ANY, 3, 127, 1'b1));
    pending.push_back(define_item(3, TYPE_MATCH, 64, 64, 1'b0));
    pending.push_back(define_item(4, TYPE_SPLIT, 4, 5, 1'b0));
    pending.push_back(define_item(5, TYPE_CLASS, 3, 127, 1'b1));
    pending.push_back(byte_item(KIND_CLASS, 5, 97));
    pending.push_back(byte_item(KIND_CLASS, 5, 255));
    // the rest of the table, so nothing undefined is ever read
    for (int i = 6; i < NS; i++) pending.push_back(rand_define(i));
    wait_idle();
    write_start(0);
    pending.push_back(byte_item(KIND_BEGIN, 63, 0));
    pending.push_back(byte_item(KIND_TEXT, 0, 97));
    pending.push_back(byte_item(KIND_TEXT, 0, 255));
    pending.push_back(byte_item(KIND_BEGIN, 0, 255));
    pending.push_back(byte_item(KIND_TEXT, 0, 98));
    pending.push_back(byte_item(KIND_TEXT, 0, 0));
    pending.push_back(byte_item(KIND_BEGIN, 0, 0));
    pending.push_back(byte_item(KIND_TEXT, 0, 255));
    pending.push_back(byte_item(KIND_TEXT, 0, 97));

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_idle();
        val = (ph == 1) ? 63 : (ph == 2) ? 0 : $urandom_range(0, 63);
        write_start(val);
      end
      calm = (ph == 3);
      for (int n = 0; n < 320; n++) pending.push_back(rand_item());
    end

    wait_idle();
    $display("covered: table loads, class adds, begins and text bytes in six phases");
    $display("results checked: %0d, of which %0d reported a match", n_results, n_matches);
    if (errors == 0) begin
      $display("nfa_regex_matcher verification clean");
    end else begin
      $display("nfa_regex_matcher verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10000000;
    $display("nfa_regex_matcher verification failed");
    $finish;
  end

endmodule

[sim.f]
design/nfarm_pkg.sv
design/nfarm_if.sv
design/nfarm_ctrl.sv
design/nfarm_dp.sv
design/nfa_regex_matcher.sv
verif/tb_top.sv
